// ===== rtl/core/isrt_pkg.sv =====
// ----------------------------------------------------------------------------
// isrt_pkg
// shared constants and the per-cell state record of the insertion sorter
// ----------------------------------------------------------------------------
package isrt_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int DATA_W        = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// what a cell shows its neighbors
	typedef struct packed {
		data_t value;
		logic  full;
		logic  gt;
	} cell_st_t;

endpackage

// ===== rtl/core/isrt_cell.sv =====
// ----------------------------------------------------------------------------
// isrt_cell
// one slot of the sorting chain: compares the incoming value with its own,
// takes the new value or its left neighbor's on insert, its right neighbor's
// on drain
// ----------------------------------------------------------------------------
module isrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              insert,
	input  logic              shift,
	input  isrt_pkg::data_t   ins_value,
	input  isrt_pkg::cell_st_t left,
	input  isrt_pkg::cell_st_t right,
	output isrt_pkg::cell_st_t self
);
	import isrt_pkg::*;

	data_t value_q;
	logic  full_q;
	logic  gt;
	logic  take;

	// stored value strictly greater moves up, new value lands after equals
	assign gt   = full_q && (value_q > ins_value);
	assign take = gt || (!full_q && left.full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (shift) begin
			full_q <= right.full;
		end else if (insert && take) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= right.value;
		end else if (insert && take) begin
			value_q <= left.gt ? left.value : ins_value;
		end
	end

	assign self.value = value_q;
	assign self.full  = full_q;
	assign self.gt    = gt;

endmodule

// ===== rtl/core/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// streaming insertion sort over sets of signed 32-bit values
// ----------------------------------------------------------------------------
// Values of a set enter one beat per cycle and are placed in sorted order at
// once by a row of DEPTH compare-and-shift cells, equal values keeping their
// arrival order. The beat marked last is inserted too and starts the drain:
// the row then shifts toward cell 0 and delivers one result per cycle in
// ascending order whenever out_ready is high, while in_ready stays low.
// Values that arrive with the row full are dropped and overflow is raised on
// every result of that set.
// ----------------------------------------------------------------------------
module insertion_sorter #(
	parameter int DEPTH = isrt_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  isrt_pkg::data_t value,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_ready,
	output isrt_pkg::data_t value_res,
	output logic            last_res,
	output logic            overflow
);
	import isrt_pkg::*;

	cell_st_t cells  [DEPTH];
	cell_st_t lefts  [DEPTH];
	cell_st_t rights [DEPTH];

	logic drain_q;
	logic dropped_q;
	logic in_acc;
	logic out_acc;
	logic store_full;
	logic insert;

	assign in_ready   = !drain_q;
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = drain_q;
	assign out_acc    = out_valid && out_ready;
	assign store_full = cells[DEPTH-1].full;
	assign insert     = in_acc && !store_full;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign lefts[i] = '{value: '0, full: 1'b1, gt: 1'b0};
			end else begin : g_mid
				assign lefts[i] = cells[i-1];
			end
			if (i == DEPTH - 1) begin : g_tail
				assign rights[i] = '{value: '0, full: 1'b0, gt: 1'b0};
			end else begin : g_body
				assign rights[i] = cells[i+1];
			end

			isrt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.insert    (insert),
				.shift     (out_acc),
				.ins_value (value),
				.left      (lefts[i]),
				.right     (rights[i]),
				.self      (cells[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (out_acc && last_res) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (in_acc) begin
			if (store_full) begin
				dropped_q <= 1'b1;
			end
			if (last) begin
				drain_q <= 1'b1;
			end
		end
	end

	assign value_res = cells[0].value;
	assign last_res  = !cells[1].full;
	assign overflow  = dropped_q;

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cells[0].full)
		else $error("drain with empty head cell");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> out_valid)
		else $error("last beat did not start the drain");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last_res |=> out_valid)
		else $error("drain ended before the final beat");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_res |=> !out_valid && !overflow && !cells[0].full)
		else $error("state not cleared after the final beat");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cells[1].full |-> cells[0].value <= cells[1].value)
		else $error("head of the row out of order");

endmodule
